>>> sv/slt_pkg.sv
// Shared types, constants and the sine table builder for the tremolo core.
// Used by slt_front, slt_queue, slt_back and sine_lfo_tremolo_core.
package slt_pkg;

  // Default sizes of the core.
  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int MAX_CHANNELS_DEF     = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Register field widths.
  localparam int DEPTH_W  = 7;
  localparam int PERIOD_W = 18;
  localparam int ANGLE_W  = 24;
  localparam int COUNT_W  = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 4'd3;

  // Register reset values.
  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 7'd25;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 18'd9600;
  localparam logic [ANGLE_W-1:0]  STEP_RST   = 24'd1747;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 4'd2;

  // Gain arithmetic: Q1.15 one, depth limit, and floor(n/200) as (n*RECIP_200)>>31.
  localparam logic [16:0] GAIN_ONE    = 17'd32768;
  localparam logic [6:0]  DEPTH_LIMIT = 7'd100;
  localparam logic [23:0] RECIP_200   = 24'd10737419;
  localparam int          RECIP_SHIFT = 31;

  // pi/2 in Q30 for the table builder.
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Live configuration.
  typedef struct packed {
    logic [DEPTH_W-1:0]  depth;
    logic [PERIOD_W-1:0] period;
    logic [ANGLE_W-1:0]  step;
    logic [COUNT_W-1:0]  count;
  } cfg_t;

  // Q1.15 sine of x (Q30 radians, 0..pi/2) by a ten-term Taylor series,
  // rounded half up and clamped. Evaluated at elaboration only.
  function automatic logic [14:0] quarter_sine(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k < 10; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

>>> sv/slt_queue.sv
// Small register queue between the front and the back of the tremolo core.
// Depends on slt_pkg for its default depth.
module slt_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = slt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import slt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill count updates; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

endmodule

>>> sv/slt_front.sv
// Front of the tremolo core: accepts samples, keeps the frame, channel and
// oscillator angle state, and queues each sample with its angle. Uses slt_pkg.
module slt_front #(
  parameter int SAMPLE_BITS  = slt_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = slt_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  slt_pkg::cfg_t                          cfg,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [SAMPLE_BITS-1:0]                 in_sample,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [slt_pkg::ANGLE_W+SAMPLE_BITS-1:0] q_data
);
  import slt_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [PERIOD_W-1:0] phase_r, phase_nxt, phase_cur;
  logic [ANGLE_W-1:0]  angle_r, angle_nxt, angle_cur;
  logic [IDX_W-1:0]    chan_r, chan_nxt;
  logic [4:0]          chans;
  logic [4:0]          chan_inc;
  logic                wrap;
  logic                frame_end;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Period wrap is checked before the sample is scaled.
  assign wrap      = (phase_r >= cfg.period);
  assign phase_cur = wrap ? '0 : phase_r;
  assign angle_cur = wrap ? '0 : angle_r;
  assign q_data    = {angle_cur, in_sample};

  // Effective channel count: zero means one, capped at the maximum.
  always_comb begin
    if (cfg.count == '0) begin
      chans = 5'd1;
    end else if ({1'b0, cfg.count} > 5'(MAX_CHANNELS)) begin
      chans = 5'(MAX_CHANNELS);
    end else begin
      chans = {1'b0, cfg.count};
    end
  end

  assign chan_inc  = 5'(chan_r) + 5'd1;
  assign frame_end = (chan_inc >= chans);

  // State update on each accepted sample; the oscillator steps at frame end.
  always_comb begin
    phase_nxt = phase_r;
    angle_nxt = angle_r;
    chan_nxt  = chan_r;
    if (q_push) begin
      if (frame_end) begin
        chan_nxt  = '0;
        phase_nxt = phase_cur + 1'b1;
        angle_nxt = angle_cur + cfg.step;
      end else begin
        chan_nxt  = IDX_W'(chan_inc);
        phase_nxt = phase_cur;
        angle_nxt = angle_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      angle_r <= '0;
      chan_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      angle_r <= angle_nxt;
      chan_r  <= chan_nxt;
    end
  end

  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    5'(chan_r) < 5'(MAX_CHANNELS))
    else $error("channel index beyond channel limit");
  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && wrap && !frame_end) |=> (phase_r == '0 && angle_r == '0))
    else $error("period wrap did not clear oscillator state");
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_push |=> ($stable(phase_r) && $stable(angle_r) && $stable(chan_r)))
    else $error("oscillator state moved without an accepted sample");

endmodule

>>> sv/slt_back.sv
// Back of the tremolo core: sine lookup, gain computation and sample scaling
// in a stalling five-stage pipeline with the output register. Uses slt_pkg.
module slt_back #(
  parameter int SAMPLE_BITS      = slt_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = slt_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  slt_pkg::cfg_t                           cfg,
  input  logic                                    q_empty,
  input  logic [slt_pkg::ANGLE_W+SAMPLE_BITS-1:0] q_data,
  output logic                                    q_pop,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [SAMPLE_BITS-1:0]                  out_sample
);
  import slt_pkg::*;

  localparam int TI_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IP_W = 22 + TI_W;
  localparam int PR_W = SAMPLE_BITS + 16;

  // Quarter-wave sine table, built at elaboration.
  logic [14:0] sine_rom [0:SINE_TABLE_DEPTH];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] X_Q30 = (PI_HALF_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[g] = quarter_sine(X_Q30);
  end

  logic                   adv;
  logic [ANGLE_W-1:0]     q_angle;
  logic [IP_W-1:0]        idx_prod;
  logic [TI_W-1:0]        idx_raw, idx_sel;
  logic [DEPTH_W-1:0]     depth_c;
  logic [15:0]            u_val;
  logic [46:0]            q_prod;
  logic [15:0]            quot;
  logic [PR_W-1:0]        s_prod;
  logic [SAMPLE_BITS-1:0] s_res;

  // Stage registers.
  logic                   v0_r, v1_r, v2_r, v3_r, out_v_r;
  logic [TI_W-1:0]        idx0_r;
  logic                   neg0_r, neg1_r;
  logic [SAMPLE_BITS-1:0] samp0_r, samp1_r, samp2_r;
  logic [14:0]            sine1_r;
  logic [22:0]            dprod2_r;
  logic [15:0]            gain3_r;
  logic                   sneg3_r;
  logic [SAMPLE_BITS-1:0] mag3_r;
  logic [SAMPLE_BITS-1:0] out_r;

  // The whole pipeline moves when the output register is free or taken.
  assign adv        = !out_v_r || out_tready;
  assign q_pop      = adv && !q_empty;
  assign out_tvalid = out_v_r;
  assign out_sample = out_r;

  // Stage 0: table index from angle bits 21..0, mirrored in odd quadrants.
  assign q_angle  = q_data[SAMPLE_BITS +: ANGLE_W];
  assign idx_prod = IP_W'(q_angle[21:0]) * IP_W'(SINE_TABLE_DEPTH);
  assign idx_raw  = idx_prod[IP_W-1:22];
  assign idx_sel  = q_angle[22] ? (TI_W'(SINE_TABLE_DEPTH) - idx_raw) : idx_raw;

  // Stage 2: offset sine 32768 +/- t times the clamped depth.
  assign depth_c = (cfg.depth > DEPTH_LIMIT) ? DEPTH_LIMIT : cfg.depth;
  assign u_val   = neg1_r ? 16'(GAIN_ONE - {2'b0, sine1_r}) : 16'(GAIN_ONE + {2'b0, sine1_r});

  // Stage 3: floor division by 200 through the reciprocal.
  assign q_prod = 47'(dprod2_r) * 47'(RECIP_200);
  assign quot   = q_prod[RECIP_SHIFT +: 16];

  // Stage 4: magnitude times gain, truncated, sign restored.
  assign s_prod = PR_W'(mag3_r) * PR_W'(gain3_r);
  assign s_res  = s_prod[15 +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v0_r    <= !q_empty;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      out_v_r <= v3_r;
    end
  end

  // Payload path needs no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      idx0_r   <= idx_sel;
      neg0_r   <= q_angle[23];
      samp0_r  <= q_data[SAMPLE_BITS-1:0];
      sine1_r  <= sine_rom[idx0_r];
      neg1_r   <= neg0_r;
      samp1_r  <= samp0_r;
      dprod2_r <= 23'(depth_c) * 23'(u_val);
      samp2_r  <= samp1_r;
      gain3_r  <= 16'(GAIN_ONE - {1'b0, quot});
      sneg3_r  <= samp2_r[SAMPLE_BITS-1];
      mag3_r   <= samp2_r[SAMPLE_BITS-1] ? (~samp2_r + 1'b1) : samp2_r;
      out_r    <= sneg3_r ? (~s_res + 1'b1) : s_res;
    end
  end

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (17'(gain3_r) <= GAIN_ONE))
    else $error("gain above unity");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v3_r) && $stable(gain3_r) && $stable(v0_r)))
    else $error("pipeline moved while output stalled");
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> v0_r)
    else $error("popped item lost in first stage");

endmodule

>>> sv/sine_lfo_tremolo_core.sv
// Tremolo core: scales interleaved audio samples by a sine LFO gain.
//
// Channels: in_* carries one signed sample per item in tdata; out_* returns
// the scaled sample, one result per input, in the same order. The cfg_*
// write port sets depth (index 0), period in frames (1), angle step in
// 2^-24 turns (2) and channel count (3); writes to other indexes are dropped.
// cfg_ready is always high; write only while no sample is in flight.
// Throughput: one sample per cycle while out_tready is high, set by the
// state update in the front and the five-stage lookup and multiply pipeline.
// A four-entry queue separates the front from the back pipeline.
// Reset: registers return to depth 25, period 9600, step 1747, two channels;
// frame, angle and channel state clear to zero.
// Stall: with out_tvalid high and out_tready low the pipeline holds, the
// queue fills and in_tready drops once full; no sample is lost or repeated.
module sine_lfo_tremolo_core #(
  parameter int SAMPLE_BITS      = slt_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = slt_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int MAX_CHANNELS     = slt_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input samples. tdata: sample_in in the low SAMPLE_BITS bits, zero padded.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  // Results. tdata: sample_out in the low SAMPLE_BITS bits, zero padded.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,
  // Configuration writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [slt_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [slt_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import slt_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int Q_W     = ANGLE_W + SAMPLE_BITS;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   q_push, q_pop, q_full, q_empty;
  logic [Q_W-1:0]         q_wdata, q_rdata;
  logic [SAMPLE_BITS-1:0] out_sample;

  // Register file writes.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DEPTH:  cfg_nxt.depth  = cfg_data[DEPTH_W-1:0];
        REG_PERIOD: cfg_nxt.period = cfg_data[PERIOD_W-1:0];
        REG_STEP:   cfg_nxt.step   = cfg_data[ANGLE_W-1:0];
        REG_COUNT:  cfg_nxt.count  = cfg_data[COUNT_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth  <= DEPTH_RST;
      cfg_r.period <= PERIOD_RST;
      cfg_r.step   <= STEP_RST;
      cfg_r.count  <= COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  slt_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  slt_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  slt_back #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sample (out_sample)
  );

  assign out_tdata = TDATA_W'(out_sample);

endmodule
